// ----- src/trial_division_prime_test_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the trial division prime test core checker
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_CORE_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define TDPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/tdpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared constants and types of the trial division prime test core.
// ----------------------------------------------------------------------------
package tdpt_pkg;

	// Default width of the tested value
	localparam int NUMBER_WIDTH_DEF = 32;

	// Width of the result field as it travels in m_tdata
	localparam int RESULT_BYTES_W = 8;

	// Status from the remainder unit
	typedef struct packed {
		logic done;      // remainder valid this cycle
		logic rem_zero;  // divisor divides the dividend
	} rem_status_t;

endpackage

// ----- src/tdpt_rem_unit.sv -----
// ----------------------------------------------------------------------------
// tdpt_rem_unit
// Restoring remainder unit: one dividend bit per cycle, MSB first. Reports
// when the remainder is ready and whether it is zero.
// ----------------------------------------------------------------------------
module tdpt_rem_unit #(
	parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF,
	parameter int DIV_W        = (NUMBER_WIDTH + 1) / 2 + 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [NUMBER_WIDTH-1:0]   dividend,
	input  logic [DIV_W-1:0]          divisor,
	output tdpt_pkg::rem_status_t     status
);

	localparam int CNT_W = $clog2(NUMBER_WIDTH + 1);

	logic [NUMBER_WIDTH-1:0] dvd_q;
	logic [DIV_W-1:0]        rem_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [DIV_W:0]          trial;
	logic [DIV_W:0]          diff;
	logic                    fits;

	// One restoring step
	assign trial = {rem_q, dvd_q[NUMBER_WIDTH-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUMBER_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NUMBER_WIDTH-2:0], 1'b0};
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign status.done     = done_q;
	assign status.rem_zero = (rem_q == '0);

endmodule

// ----- src/trial_division_prime_test_core.sv -----
// ----------------------------------------------------------------------------
// trial_division_prime_test_core
// Tests one signed value per item for primality by trial division.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (low bit up)              Handshake
// s_axis   in   number[NUMBER_WIDTH-1:0], pad    s_tvalid / s_tready
// m_axis   out  is_prime[0], zeros[7:1]          m_tvalid / m_tready
//
// Flow: negatives, 0..3 and even values go from S_PRE straight to S_FIN. Otherwise
// each odd divisor d from 3 upward with d*d <= number is tried in turn in the shared
// bit-serial remainder unit; about 23170 divisors worst case at 32 bits.
// Reset: arst_n clears the sequencer and the output valid.
// Stalls: s_tready is high only when idle; a finished verdict waits in S_FIN
// while the output register still holds an unaccepted result.
// ----------------------------------------------------------------------------
module trial_division_prime_test_core #(
	parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]   s_tdata,   // number, then zero pad
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tdpt_pkg::RESULT_BYTES_W-1:0] m_tdata    // is_prime, then zero pad
);

	localparam int DIV_W = (NUMBER_WIDTH + 1) / 2 + 1;
	localparam int SQ_W  = NUMBER_WIDTH + 2;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PRE   = 5'b00010,
		S_CHECK = 5'b00100,
		S_DIV   = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [NUMBER_WIDTH-1:0] value_q;
	logic [DIV_W-1:0]        d_q;
	logic [SQ_W-1:0]         sq_q;
	logic                    prime_q;
	logic                    out_valid_q;
	logic                    out_prime_q;
	logic                    div_start;
	logic                    out_free;
	tdpt_pkg::rem_status_t   rem_st;

	assign s_tready  = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || m_tready;
	assign div_start = (state_q == S_CHECK) && (sq_q <= SQ_W'(value_q));

	// Shared remainder unit
	tdpt_rem_unit #(
		.NUMBER_WIDTH (NUMBER_WIDTH),
		.DIV_W        (DIV_W)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (value_q),
		.divisor  (d_q),
		.status   (rem_st)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_PRE;
				end
				S_PRE: begin
					if (value_q[NUMBER_WIDTH-1] || value_q[NUMBER_WIDTH-1:2] == '0
					    || !value_q[0])
						state_q <= S_FIN;
					else
						state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= div_start ? S_DIV : S_FIN;
				end
				S_DIV: begin
					if (rem_st.done) state_q <= rem_st.rem_zero ? S_FIN : S_CHECK;
				end
				S_FIN: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item datapath: value, divisor, its square, verdict
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) value_q <= s_tdata[NUMBER_WIDTH-1:0];
			end
			S_PRE: begin
				d_q  <= DIV_W'(3);
				sq_q <= SQ_W'(9);
				// 2 and 3 prime; negatives, 0, 1 and even values not
				if (value_q[NUMBER_WIDTH-1] || value_q[NUMBER_WIDTH-1:1] == '0)
					prime_q <= 1'b0;
				else if (value_q[NUMBER_WIDTH-1:2] == '0)
					prime_q <= 1'b1;
				else
					prime_q <= 1'b0;
			end
			S_CHECK: begin
				if (!div_start) prime_q <= 1'b1;
			end
			S_DIV: begin
				if (rem_st.done) begin
					prime_q <= 1'b0;
					// (d+2)^2 = d^2 + 4d + 4
					d_q  <= d_q + DIV_W'(2);
					sq_q <= sq_q + SQ_W'({d_q, 2'b00}) + SQ_W'(4);
				end
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) out_prime_q <= prime_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(tdpt_pkg::RESULT_BYTES_W - 1)'(0), out_prime_q};

endmodule

// ----- src/tdpt_checker.sv -----
// ----------------------------------------------------------------------------
// tdpt_checker
// Port-level checks of the trial division prime test core, bound to the top.
// ----------------------------------------------------------------------------
`include "trial_division_prime_test_core_macros.svh"

module tdpt_checker #(
	parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic [((NUMBER_WIDTH+7)/8)*8-1:0]   s_tdata,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [tdpt_pkg::RESULT_BYTES_W-1:0] m_tdata
);

	// A stalled result holds
	`TDPT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "not held")

	// One item at a time: intake closes right after an accept
	`TDPT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "intake while busy")

	// Only the verdict bit is ever set
	`TDPT_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[tdpt_pkg::RESULT_BYTES_W-1:1] == '0, "pad")

	// No verdict can show up on the cycle right after an item is taken
	`TDPT_ASSERT_NEXT(a_no_early, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "early result")

endmodule

bind trial_division_prime_test_core tdpt_checker #(
	.NUMBER_WIDTH (NUMBER_WIDTH)
) u_tdpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams signed values into the trial division prime test core and checks
// each verdict in order against a predictor that divides by 2 and by the odd
// divisors up to the square root. A directed set covers the signs, the
// boundary values, squares of primes and a few medium primes. Random values
// follow, kept small, negative, even or built from a small odd factor so that
// each one stays cheap for the bit-serial remainder unit.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF;
	localparam int DATA_W       = ((NUMBER_WIDTH + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 76;
	localparam int TAIL_CYCLES  = 50;
	localparam int LIMIT_CYCLES = 2_000_000;

	typedef struct {
		logic [DATA_W-1:0] number;
		bit                hold_for_drain;  // wait until no verdict is outstanding
	} test_item_t;

	logic                                clk;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [DATA_W-1:0]                   s_tdata;   // number, then zero pad
	logic                                m_tvalid;
	logic                                m_tready;
	logic [tdpt_pkg::RESULT_BYTES_W-1:0] m_tdata;   // is_prime, then zero pad

	test_item_t  pending_numbers[$];
	bit          verdicts_due[$];
	int          gap_left;
	int          burst_left;
	int          ready_mode;
	int          ready_phase_left;
	int          errors = 0;
	int unsigned odd_factors[12] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 97};

	trial_division_prime_test_core #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// Expected verdict: negatives and values below 2 are not prime
	function automatic bit is_prime_by_trial(logic [NUMBER_WIDTH-1:0] value);
		longint unsigned v;
		longint unsigned d;
		if (value[NUMBER_WIDTH-1])
			return 1'b0;
		v = value;
		if (v < 2)
			return 1'b0;
		if (v < 4)
			return 1'b1;
		if (v[0] == 1'b0)
			return 1'b0;
		for (d = 3; d * d <= v; d += 2) begin
			if (v % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Driver: bursts of items with random gaps, optional drain before an item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			gap_left   <= 0;
			burst_left <= $urandom_range(1, 8);
		end else begin : drive
			logic       present;
			test_item_t next_item;
			if (s_tvalid && s_tready)
				verdicts_due.push_back(is_prime_by_trial(s_tdata[NUMBER_WIDTH-1:0]));
			present = s_tvalid && !s_tready;
			if (!present) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_numbers.size() != 0 &&
						!(pending_numbers[0].hold_for_drain && verdicts_due.size() != 0)) begin
					next_item = pending_numbers.pop_front();
					s_tdata   <= next_item.number;
					present   = 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 8);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
			s_tvalid <= present;
		end
	end

	// Monitor: ready follows its own mix of stretches, checks each verdict
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready         <= 1'b0;
			ready_mode       <= 0;
			ready_phase_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdicts_due.size() == 0) begin
					$error("is_prime: result 0x%0h with no item outstanding", m_tdata);
					errors++;
				end else begin : compare
					bit verdict;
					verdict = verdicts_due.pop_front();
					if (m_tdata[0] !== verdict) begin
						$error("is_prime: expected %0b, got %0b", verdict, m_tdata[0]);
						errors++;
					end
					if (m_tdata[tdpt_pkg::RESULT_BYTES_W-1:1] !== '0) begin
						$error("pad: expected 0, got 0x%0h",
							m_tdata[tdpt_pkg::RESULT_BYTES_W-1:1]);
						errors++;
					end
				end
			end
			if (ready_phase_left == 0) begin
				ready_mode       <= $urandom_range(0, 2);
				ready_phase_left <= $urandom_range(4, 40);
			end else begin
				ready_phase_left <= ready_phase_left - 1;
			end
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Run limit
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	// Stimulus and end of run
	initial begin : main
		logic [DATA_W-1:0] directed[$];
		test_item_t        item;
		int unsigned       pick;
		int unsigned       factor;
		int unsigned       mult_max;
		arst_n   = 1'b0;

		// Zero, one, smallest primes, even composite, squares of primes,
		// negatives, largest even, large odd composites and medium primes
		directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25,
			32'd49, 32'd121, 32'd97, 32'd1009, 32'd1018081, 32'd8191, 32'd65521,
			32'd65537, 32'd999983, 32'd1000003, 32'hFFFF_FFFF, 32'h8000_0000,
			32'hFFFF_FFF9, 32'h7FFF_FFFE, 32'd2147483645, 32'd2147483643};
		foreach (directed[i]) begin
			item.number         = directed[i];
			item.hold_for_drain = 1'b0;
			pending_numbers.push_back(item);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				item.number = $urandom_range(0, 16383);
			end else if (pick < 75) begin
				item.number = {1'b1, 31'($urandom_range(0, 32'h7FFF_FFFF))};
			end else if (pick < 85) begin
				item.number = {1'b0, 31'($urandom_range(0, 32'h7FFF_FFFF))};
				item.number[0] = 1'b0;
			end else begin
				// Odd value with a small factor, spread over the whole positive range
				factor   = odd_factors[$urandom_range(0, 11)];
				mult_max = 32'h7FFF_FFFF / factor;
				item.number = factor * ($urandom_range(0, (mult_max - 1) / 2) * 2 + 1);
			end
			item.hold_for_drain = (i == 0) || (i == RANDOM_ITEMS / 2);
			pending_numbers.push_back(item);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk); while (pending_numbers.size() != 0 || s_tvalid);
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/tdpt_pkg.sv
src/tdpt_rem_unit.sv
src/trial_division_prime_test_core.sv
src/tdpt_checker.sv
sim/testbench.sv
